// ===== rtl/rgbu_pkg.sv =====
`timescale 1ns / 1ps

package rgbu_pkg;

   // Line buffer sizing
   localparam int MAX_WIDTH  = 4096;
   localparam int LINE_DEPTH = 3 * MAX_WIDTH;
   localparam int COL_W      = $clog2(LINE_DEPTH);
   localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
   localparam int WEFF_W     = $clog2(MAX_WIDTH + 1);

   // Register file
   localparam int WIDTH_W  = 13;
   localparam int HEIGHT_W = 16;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_kind_type;

   // Sample handed from the sequencer to the reconstruction stage
   typedef struct packed {
      logic [7:0]      raw;
      logic [COL_W-1:0] col;
      logic [1:0]      ch;
      filter_kind_type filt;
      logic            has_left;
      logic            has_up;
      logic            eor;
      logic            eoi;
      logic            bad;
   } item_type;

endpackage

// ===== rtl/rgbu_ram.sv =====
`timescale 1ns / 1ps

module rgbu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rgbu_seq.sv =====
`timescale 1ns / 1ps

// Row/column sequencer: takes bytes, tracks position, issues line buffer reads.
module rgbu_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_raw_byte,
   input  logic [rgbu_pkg::WIDTH_W-1:0]     image_width,
   input  logic [rgbu_pkg::HEIGHT_W-1:0]    image_height,
   input  logic                             item_take,
   output logic                             item_valid,
   output rgbu_pkg::item_type               item,
   output logic                             rd_en,
   output logic [rgbu_pkg::COL_W-1:0]       rd_addr
);

   logic [rgbu_pkg::COL_W-1:0]  col_ff, col_in;
   logic [1:0]                  ch_ff, ch_in;
   logic [rgbu_pkg::HEIGHT_W-1:0] row_ff, row_in;
   logic                        await_ff, await_in;
   logic                        bad_ff, bad_in;
   rgbu_pkg::filter_kind_type   filt_ff, filt_in;
   logic                        item_valid_ff, item_valid_in;
   rgbu_pkg::item_type          item_ff, item_in;

   logic                         accept;
   logic [31:0]                  w_ext;
   logic [rgbu_pkg::WEFF_W-1:0]  w_eff;
   logic [rgbu_pkg::LEN_W-1:0]   row_len;
   logic [rgbu_pkg::LEN_W-1:0]   col_next;
   logic [rgbu_pkg::HEIGHT_W:0]  row_next;
   logic [rgbu_pkg::HEIGHT_W:0]  height_eff;
   logic                         row_end;
   logic                         img_end;

   assign req_stall = item_valid_ff && !item_take;
   assign accept    = req_valid && !req_stall;

   // Clamp width to 1..MAX_WIDTH, row length is three bytes per pixel
   always_comb begin
      w_ext = 32'(image_width);
      if (w_ext == 32'd0) begin
         w_eff = rgbu_pkg::WEFF_W'(1);
      end else if (w_ext > 32'(rgbu_pkg::MAX_WIDTH)) begin
         w_eff = rgbu_pkg::WEFF_W'(rgbu_pkg::MAX_WIDTH);
      end else begin
         w_eff = rgbu_pkg::WEFF_W'(w_ext);
      end
      row_len    = rgbu_pkg::LEN_W'(w_eff) + (rgbu_pkg::LEN_W'(w_eff) << 1);
      height_eff = (image_height == '0) ? (rgbu_pkg::HEIGHT_W+1)'(1)
                                        : {1'b0, image_height};
   end

   assign col_next = rgbu_pkg::LEN_W'(col_ff) + rgbu_pkg::LEN_W'(1);
   assign row_next = {1'b0, row_ff} + (rgbu_pkg::HEIGHT_W+1)'(1);
   assign row_end  = col_next >= row_len;
   assign img_end  = row_end && (row_next >= height_eff);

   assign rd_en   = accept && !await_ff;
   assign rd_addr = col_ff;

   always_comb begin
      col_in        = col_ff;
      ch_in         = ch_ff;
      row_in        = row_ff;
      await_in      = await_ff;
      bad_in        = bad_ff;
      filt_in       = filt_ff;
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !item_take;

      if (accept) begin
         if (await_ff) begin
            // filter type byte
            if (req_raw_byte <= 8'd4) begin
               filt_in = rgbu_pkg::filter_kind_type'(req_raw_byte[2:0]);
               bad_in  = 1'b0;
            end else begin
               bad_in  = 1'b1;
            end
            col_in   = '0;
            ch_in    = 2'd0;
            await_in = 1'b0;
         end else begin
            item_in.raw      = req_raw_byte;
            item_in.col      = col_ff;
            item_in.ch       = ch_ff;
            item_in.filt     = filt_ff;
            item_in.has_left = col_ff >= rgbu_pkg::COL_W'(3);
            item_in.has_up   = row_ff != '0;
            item_in.eor      = row_end;
            item_in.eoi      = img_end;
            item_in.bad      = bad_ff;
            item_valid_in    = 1'b1;

            col_in = rgbu_pkg::COL_W'(col_next);
            ch_in  = (ch_ff == 2'd2) ? 2'd0 : ch_ff + 2'd1;
            if (row_end) begin
               col_in   = '0;
               ch_in    = 2'd0;
               await_in = 1'b1;
               row_in   = rgbu_pkg::HEIGHT_W'(row_next);
               if (img_end) begin
                  row_in  = '0;
                  filt_in = rgbu_pkg::FILT_NONE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         ch_ff         <= 2'd0;
         row_ff        <= '0;
         await_ff      <= 1'b1;
         bad_ff        <= 1'b0;
         filt_ff       <= rgbu_pkg::FILT_NONE;
         item_valid_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         ch_ff         <= ch_in;
         row_ff        <= row_in;
         await_ff      <= await_in;
         bad_ff        <= bad_in;
         filt_ff       <= filt_in;
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/rgbu_recon.sv =====
`timescale 1ns / 1ps

// Predictor and output register; writes reconstructed bytes back to the line buffer.
module rgbu_recon (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  rgbu_pkg::item_type          item,
   output logic                        item_take,
   input  logic [7:0]                  up_byte,
   output logic                        wr_en,
   output logic [rgbu_pkg::COL_W-1:0]  wr_addr,
   output logic [7:0]                  wr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_pixel_value,
   output logic [1:0]                  rsp_channel,
   output logic                        rsp_end_of_row,
   output logic                        rsp_end_of_image,
   output logic                        rsp_bad_filter
);

   logic [7:0] left_ff [3];
   logic [7:0] ul_ff   [3];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] pix_ff;
   logic [1:0] ch_ff;
   logic       eor_ff, eoi_ff, bad_ff;

   logic [7:0]        a, b, c, pred, val;
   logic [7:0]        left_sel, ul_sel;
   logic [8:0]        sum_ab;
   logic signed [9:0] d_bc, d_ac, d_sum;
   logic [9:0]        pa, pb, pc;

   assign item_take = item_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      unique case (item.ch)
         2'd0:    begin left_sel = left_ff[0]; ul_sel = ul_ff[0]; end
         2'd1:    begin left_sel = left_ff[1]; ul_sel = ul_ff[1]; end
         2'd2:    begin left_sel = left_ff[2]; ul_sel = ul_ff[2]; end
         default: begin left_sel = 8'd0;       ul_sel = 8'd0;       end
      endcase
      a = item.has_left ? left_sel : 8'd0;
      b = item.has_up ? up_byte : 8'd0;
      c = (item.has_left && item.has_up) ? ul_sel : 8'd0;

      sum_ab = {1'b0, a} + {1'b0, b};
      d_bc   = $signed({2'b00, b}) - $signed({2'b00, c});
      d_ac   = $signed({2'b00, a}) - $signed({2'b00, c});
      d_sum  = d_bc + d_ac;
      pa     = (d_bc < 0) ? 10'(-d_bc) : 10'(d_bc);
      pb     = (d_ac < 0) ? 10'(-d_ac) : 10'(d_ac);
      pc     = (d_sum < 0) ? 10'(-d_sum) : 10'(d_sum);

      unique case (item.filt)
         rgbu_pkg::FILT_SUB: pred = a;
         rgbu_pkg::FILT_UP:  pred = b;
         rgbu_pkg::FILT_AVG: pred = sum_ab[8:1];
         rgbu_pkg::FILT_PAETH: begin
            priority if (pa <= pb && pa <= pc) begin
               pred = a;
            end else if (pb <= pc) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default: pred = 8'd0;
      endcase
      val = item.raw + pred;
   end

   assign wr_en   = item_take;
   assign wr_addr = item.col;
   assign wr_data = val;

   assign rsp_valid_in = item_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (item_take) begin
         pix_ff <= val;
         ch_ff  <= item.ch;
         eor_ff <= item.eor;
         eoi_ff <= item.eoi;
         bad_ff <= item.bad;
         unique case (item.ch)
            2'd0:    begin left_ff[0] <= val; ul_ff[0] <= b; end
            2'd1:    begin left_ff[1] <= val; ul_ff[1] <= b; end
            2'd2:    begin left_ff[2] <= val; ul_ff[2] <= b; end
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_value  = pix_ff;
   assign rsp_channel      = ch_ff;
   assign rsp_end_of_row   = eor_ff;
   assign rsp_end_of_image = eoi_ff;
   assign rsp_bad_filter   = bad_ff;

endmodule

// ===== rtl/png_rgb8_unfilter.sv =====
`timescale 1ns / 1ps
// An accepted sample passes the sequencer item register, then the output register, to rsp_*.
// Throughput: one byte per cycle unless rsp_stall backs up, filter type bytes included (no output).
// Rate is set by the line buffer: one read and one write port, both used every sample cycle.
// Reset (synchronous, active high) resets sequencing state, valid flags and the size registers
// to one; the line buffer keeps its contents and is not cleared (first-row up bytes are masked).
module png_rgb8_unfilter (
   input  logic                          clock,
   input  logic                          reset,
   // byte input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_raw_byte,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_pixel_value,
   output logic [1:0]                    rsp_channel,
   output logic                          rsp_end_of_row,
   output logic                          rsp_end_of_image,
   output logic                          rsp_bad_filter,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rgbu_pkg::PADDR_W-1:0]  paddr,
   input  logic [rgbu_pkg::PDATA_W-1:0]  pwdata,
   output logic [rgbu_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);

   // Configuration registers: image_width at 0x0, image_height at 0x4.
   logic [rgbu_pkg::WIDTH_W-1:0]  width_ff, width_in;
   logic [rgbu_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic                          csr_write;
   logic                          csr_sel;

   // Stage between sequencer and reconstruction
   logic                          item_valid;
   logic                          item_take;
   rgbu_pkg::item_type            item;

   // Line buffer ports
   logic                          rd_en;
   logic [rgbu_pkg::COL_W-1:0]    rd_addr;
   logic [7:0]                    rd_data;
   logic                          wr_en;
   logic [rgbu_pkg::COL_W-1:0]    wr_addr;
   logic [7:0]                    wr_data;

   assign pready    = 1'b1;
   assign csr_sel   = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_sel)
            rgbu_pkg::REG_IMAGE_WIDTH:  width_in  = pwdata[rgbu_pkg::WIDTH_W-1:0];
            rgbu_pkg::REG_IMAGE_HEIGHT: height_in = pwdata[rgbu_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         rgbu_pkg::REG_IMAGE_WIDTH:  prdata = rgbu_pkg::PDATA_W'(width_ff);
         rgbu_pkg::REG_IMAGE_HEIGHT: prdata = rgbu_pkg::PDATA_W'(height_ff);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rgbu_pkg::WIDTH_W'(1);
         height_ff <= rgbu_pkg::HEIGHT_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Sequencer: position tracking, filter type capture, line buffer read-ahead.
   // The read of column k is issued on the accepting edge so the up byte is
   // on rd_data when the sample sits in the reconstruction stage.
   rgbu_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_raw_byte (req_raw_byte),
      .image_width  (width_ff),
      .image_height (height_ff),
      .item_take    (item_take),
      .item_valid   (item_valid),
      .item         (item),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr)
   );

   // Line buffer. Reads only happen on accepted samples, so rd_data holds
   // while the stage is stalled. A column is written back a full row plus the
   // type byte before it is read again, so read and write never hit the same
   // entry in one cycle and no forwarding is needed.
   rgbu_ram #(
      .WIDTH (8),
      .DEPTH (rgbu_pkg::LINE_DEPTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Reconstruction: left and upper-left bytes come from per-channel
   // registers updated by the previous pixel, which forwards the left byte
   // without a memory round trip.
   rgbu_recon u_recon (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .up_byte          (rd_data),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_channel      (rsp_channel),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_image (rsp_end_of_image),
      .rsp_bad_filter   (rsp_bad_filter)
   );

endmodule

// ===== rtl/rgbu_checker.sv =====
`timescale 1ns / 1ps

module rgbu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_channel,
   input logic       rsp_end_of_row,
   input logic       rsp_end_of_image
);

   // output transaction must not drop while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped under stall");

   // last byte of an image is always the last byte of a row
   a_eoi_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_image |-> rsp_end_of_row)
      else $error("end_of_image without end_of_row");

   a_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_channel != 2'd3)
      else $error("illegal channel code");

   // nothing comes out in the cycle after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

endmodule

bind png_rgb8_unfilter rgbu_checker u_rgbu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_channel      (rsp_channel),
   .rsp_end_of_row   (rsp_end_of_row),
   .rsp_end_of_image (rsp_end_of_image)
);

// ===== test/png_rgb8_unfilter_tb.sv =====
`timescale 1ns / 1ps

module png_rgb8_unfilter_tb;

   // Run length guard: about 1500 bytes plus register traffic
   // and one long hold-off, taken many times over
   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned RANDOM_BYTES = 1000;
   localparam int unsigned FULL_ROW = 32'hFFFF_FFFF;
   // Settle time after the last result: one stage plus the output register
   localparam int unsigned DRAIN_CYCLES = 4;

   // One reconstructed sample as it leaves the block
   typedef struct packed {
      logic [7:0] pix;
      logic [1:0] chan;
      logic       eor;
      logic       eoi;
      logic       bad;
   } pixel_type;

   // Directed stimulus row: the byte to send and, for samples, the result read off by hand
   typedef struct packed {
      logic [7:0] raw;
      logic       gives;
      pixel_type  want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_raw_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_pixel_value;
   logic [1:0]  rsp_channel;
   logic        rsp_end_of_row;
   logic        rsp_end_of_image;
   logic        rsp_bad_filter;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [rgbu_pkg::PADDR_W-1:0] paddr;
   logic [rgbu_pkg::PDATA_W-1:0] pwdata;
   logic [rgbu_pkg::PDATA_W-1:0] prdata;
   logic        pready;

   png_rgb8_unfilter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_byte     (req_raw_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_channel      (rsp_channel),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_image (rsp_end_of_image),
      .rsp_bad_filter   (rsp_bad_filter),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state: a private copy of the unfilter datapath
   // ------------------------------------------------------------------
   logic [7:0]      line_copy [0:rgbu_pkg::LINE_DEPTH-1];
   logic [23:0]     left_px;
   logic [23:0]     upleft_px;
   rgbu_pkg::filter_kind_type cur_filter;
   logic            row_bad;
   int unsigned     col_no;
   int unsigned     row_no;
   logic            want_type;
   logic [rgbu_pkg::WIDTH_W-1:0]  cfg_width;
   logic [rgbu_pkg::HEIGHT_W-1:0] cfg_height;

   pixel_type   pending_pixels [$];
   int unsigned errors = 0;
   int unsigned sent_items = 0;
   int unsigned results_seen = 0;
   int unsigned cycles = 0;
   bit          steady = 1'b0;     // no idling on either side while set
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;

   // After reset: width 1, height 1, so every row is one pixel with no neighbours.
   // Each sample comes out unchanged whatever the filter; the last one closes row and image.
   dir_row_type dir_rows [24] = '{
      '{8'(rgbu_pkg::FILT_NONE),  1'b0, '{8'h00, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h00,                    1'b1, '{8'h00, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'hFF,                    1'b1, '{8'hFF, 2'd1, 1'b0, 1'b0, 1'b0}},
      '{8'h80,                    1'b1, '{8'h80, 2'd2, 1'b1, 1'b1, 1'b0}},
      '{8'(rgbu_pkg::FILT_SUB),   1'b0, '{8'h00, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h01,                    1'b1, '{8'h01, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h7F,                    1'b1, '{8'h7F, 2'd1, 1'b0, 1'b0, 1'b0}},
      '{8'hFE,                    1'b1, '{8'hFE, 2'd2, 1'b1, 1'b1, 1'b0}},
      '{8'(rgbu_pkg::FILT_UP),    1'b0, '{8'h00, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h55,                    1'b1, '{8'h55, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'hAA,                    1'b1, '{8'hAA, 2'd1, 1'b0, 1'b0, 1'b0}},
      '{8'h00,                    1'b1, '{8'h00, 2'd2, 1'b1, 1'b1, 1'b0}},
      '{8'(rgbu_pkg::FILT_AVG),   1'b0, '{8'h00, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'hFF,                    1'b1, '{8'hFF, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'hFF,                    1'b1, '{8'hFF, 2'd1, 1'b0, 1'b0, 1'b0}},
      '{8'h01,                    1'b1, '{8'h01, 2'd2, 1'b1, 1'b1, 1'b0}},
      '{8'(rgbu_pkg::FILT_PAETH), 1'b0, '{8'h00, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h80,                    1'b1, '{8'h80, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h01,                    1'b1, '{8'h01, 2'd1, 1'b0, 1'b0, 1'b0}},
      '{8'hFF,                    1'b1, '{8'hFF, 2'd2, 1'b1, 1'b1, 1'b0}},
      // unknown filter type: flagged on every sample of the row
      '{8'hFF,                    1'b0, '{8'h00, 2'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h12,                    1'b1, '{8'h12, 2'd0, 1'b0, 1'b0, 1'b1}},
      '{8'h34,                    1'b1, '{8'h34, 2'd1, 1'b0, 1'b0, 1'b1}},
      '{8'hFF,                    1'b1, '{8'hFF, 2'd2, 1'b1, 1'b1, 1'b1}}
   };

   // Advance the predictor by one accepted byte; got is set when a sample comes out
   task automatic unfilter_step(input logic [7:0] b, output pixel_type px, output bit got);
      int unsigned w, len, hgt, sh;
      logic [7:0]  a, up, c, pred, pix;
      int          pa, pb, pc;
      bit          has_left, has_up;
      w = (cfg_width == 0) ? 1 : ((cfg_width > rgbu_pkg::MAX_WIDTH) ? rgbu_pkg::MAX_WIDTH
                                                                     : cfg_width);
      len = 3 * w;
      hgt = (cfg_height == 0) ? 1 : cfg_height;
      got = 1'b0;
      px = '0;
      if (want_type) begin
         // filter type byte: an unknown code keeps the previous filter
         if (b <= 8'd4) begin
            cur_filter = rgbu_pkg::filter_kind_type'(b[2:0]);
            row_bad = 1'b0;
         end else begin
            row_bad = 1'b1;
         end
         left_px = '0;
         upleft_px = '0;
         col_no = 0;
         want_type = 1'b0;
      end else begin
         sh = 8 * (col_no % 3);
         has_left = col_no >= 3;
         has_up = row_no != 0;
         a = has_left ? left_px[sh +: 8] : 8'h00;
         up = (has_up && col_no < rgbu_pkg::LINE_DEPTH) ? line_copy[col_no] : 8'h00;
         c = (has_left && has_up) ? upleft_px[sh +: 8] : 8'h00;
         case (cur_filter)
            rgbu_pkg::FILT_SUB:   pred = a;
            rgbu_pkg::FILT_UP:    pred = up;
            rgbu_pkg::FILT_AVG:   pred = 8'((9'(a) + 9'(up)) >> 1);
            rgbu_pkg::FILT_PAETH: begin
               pa = int'(up) - int'(c);
               pb = int'(a) - int'(c);
               pc = int'(a) + int'(up) - 2 * int'(c);
               if (pa < 0) pa = -pa;
               if (pb < 0) pb = -pb;
               if (pc < 0) pc = -pc;
               if (pa <= pb && pa <= pc) pred = a;
               else if (pb <= pc) pred = up;
               else pred = c;
            end
            default:    pred = 8'h00;
         endcase
         pix = b + pred;
         if (col_no < rgbu_pkg::LINE_DEPTH)
            line_copy[col_no] = pix;
         left_px[sh +: 8] = pix;
         upleft_px[sh +: 8] = up;
         px.pix = pix;
         px.chan = 2'(col_no % 3);
         px.bad = row_bad;
         col_no++;
         // row and image lengths follow the registers as they stand now
         if (col_no >= len) begin
            px.eor = 1'b1;
            col_no = 0;
            want_type = 1'b1;
            row_no++;
            if (row_no >= hgt) begin
               px.eoi = 1'b1;
               row_no = 0;
               cur_filter = rgbu_pkg::FILT_NONE;
            end
         end
         got = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------
   // Sender: called at a falling edge, returns at the falling edge after acceptance
   // ------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input bit typed, input pixel_type want);
      pixel_type px;
      bit        got;
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_byte <= b;
      do @(posedge clock); while (req_stall);
      // transaction taken at this edge
      sent_items++;
      unfilter_step(b, px, got);
      if (got)
         pending_pixels.push_back(typed ? want : px);
      @(negedge clock);
   endtask

   // Finish the current row: a type byte if one is due, then samples up to max_samples
   task automatic send_row(input int unsigned max_samples);
      int unsigned n;
      int unsigned r;
      logic [7:0]  b;
      n = 0;
      if (want_type) begin
         r = $urandom_range(99);
         b = (r < 12) ? 8'($urandom_range(5, 255)) : 8'($urandom_range(0, 4));
         push_byte(b, 1'b0, '0);
      end
      while (!want_type && n < max_samples) begin
         r = $urandom_range(99);
         b = (r < 10) ? 8'h00 : ((r < 20) ? 8'hFF : 8'($urandom));
         push_byte(b, 1'b0, '0);
         n++;
      end
   endtask

   // Wait until every expected sample is out, then let the pipeline empty
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_image();
      do begin
         // now and then the sender holds off until the block has drained
         if ($urandom_range(99) < 5)
            settle_block();
         send_row(FULL_ROW);
      end while (row_no != 0);
   endtask

   // Register port: setup then access, then idle before returning
   task automatic csr_access(input logic wr, input logic idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Write a register while idle, junk in the unused upper bits, then read it back
   task automatic write_reg(input logic idx, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] rd;
      settle_block();
      mask = (idx == rgbu_pkg::REG_IMAGE_WIDTH) ? ((32'h1 << rgbu_pkg::WIDTH_W) - 1)
                                                : ((32'h1 << rgbu_pkg::HEIGHT_W) - 1);
      csr_access(1'b1, idx, (value & mask) | (32'($urandom) & ~mask), rd);
      if (idx == rgbu_pkg::REG_IMAGE_WIDTH)
         cfg_width = value[rgbu_pkg::WIDTH_W-1:0];
      else
         cfg_height = value[rgbu_pkg::HEIGHT_W-1:0];
      csr_access(1'b0, idx, 32'h0, rd);
      if ((rd & mask) !== (value & mask)) begin
         $display("%0t register %0d readback: expected %0h actual %0h",
                  $time, idx, value & mask, rd & mask);
         errors++;
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stalls plus one long hold-off so the input backs up
   // ------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_seen >= 300 && req_valid) begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 24);
         end
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Result monitor: each transaction is matched against the oldest expectation
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_pixels.size() == 0) begin
            $display("%0t unexpected result: expected none actual %0h ch %0d",
                     $time, rsp_pixel_value, rsp_channel);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_value", want.pix, rsp_pixel_value);
            check_field("channel", 8'(want.chan), 8'(rsp_channel));
            check_field("end_of_row", 8'(want.eor), 8'(rsp_end_of_row));
            check_field("end_of_image", 8'(want.eoi), 8'(rsp_end_of_image));
            check_field("bad_filter", 8'(want.bad), 8'(rsp_bad_filter));
         end
      end
   end

   // Hang guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned mark;
      int unsigned r;
      logic [31:0] w;
      logic [31:0] h;
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_byte = 8'h00;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      foreach (line_copy[i]) line_copy[i] = 8'h00;
      left_px = '0;
      upleft_px = '0;
      cur_filter = rgbu_pkg::FILT_NONE;
      row_bad = 1'b0;
      col_no = 0;
      row_no = 0;
      want_type = 1'b1;
      cfg_width = 1;
      cfg_height = 1;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every filter and an unknown type at the reset geometry
      foreach (dir_rows[i])
         push_byte(dir_rows[i].raw, 1'b1, dir_rows[i].want);

      // random geometry, small images, mostly valid filter types
      mark = sent_items;
      while (sent_items - mark < RANDOM_BYTES) begin
         r = $urandom_range(99);
         w = (r < 8) ? 0 : ((r < 12) ? $urandom_range(9, 40) : $urandom_range(1, 6));
         r = $urandom_range(99);
         h = (r < 10) ? 0 : $urandom_range(1, 5);
         write_reg(rgbu_pkg::REG_IMAGE_WIDTH, w);
         write_reg(rgbu_pkg::REG_IMAGE_HEIGHT, h);
         repeat ($urandom_range(1, 3)) send_image();
      end

      // width above the maximum saturates: the row runs on well past any short length,
      // then a narrow width closes it on the next sample
      write_reg(rgbu_pkg::REG_IMAGE_WIDTH, 32'h1FFF);
      write_reg(rgbu_pkg::REG_IMAGE_HEIGHT, 1);
      send_row(40);
      write_reg(rgbu_pkg::REG_IMAGE_WIDTH, 1);
      send_image();

      // longer rows, three of them so the up neighbor is used; no idling
      write_reg(rgbu_pkg::REG_IMAGE_WIDTH, 40);
      write_reg(rgbu_pkg::REG_IMAGE_HEIGHT, 3);
      steady = 1'b1;
      send_image();
      settle_block();
      steady = 1'b0;

      // tallest image cut short: height lowered below the current row count
      write_reg(rgbu_pkg::REG_IMAGE_WIDTH, 2);
      write_reg(rgbu_pkg::REG_IMAGE_HEIGHT, 32'hFFFF);
      repeat (3) send_row(FULL_ROW);
      write_reg(rgbu_pkg::REG_IMAGE_HEIGHT, 2);
      send_image();

      // width narrowed in the middle of a row: the row ends on the next sample
      write_reg(rgbu_pkg::REG_IMAGE_WIDTH, 5);
      write_reg(rgbu_pkg::REG_IMAGE_HEIGHT, 3);
      send_row(FULL_ROW);
      send_row(4);
      write_reg(rgbu_pkg::REG_IMAGE_WIDTH, 1);
      send_image();

      // width raised between rows; the line buffer was filled by the wider images before
      write_reg(rgbu_pkg::REG_IMAGE_WIDTH, 2);
      write_reg(rgbu_pkg::REG_IMAGE_HEIGHT, 4);
      repeat (2) send_row(FULL_ROW);
      write_reg(rgbu_pkg::REG_IMAGE_WIDTH, 6);
      send_image();

      // zero width and zero height both act as one
      write_reg(rgbu_pkg::REG_IMAGE_WIDTH, 0);
      write_reg(rgbu_pkg::REG_IMAGE_HEIGHT, 0);
      repeat (2) send_image();

      settle_block();
      repeat (8) @(negedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== png_rgb8_unfilter.f =====
rtl/rgbu_pkg.sv
rtl/rgbu_ram.sv
rtl/rgbu_seq.sv
rtl/rgbu_recon.sv
rtl/png_rgb8_unfilter.sv
rtl/rgbu_checker.sv
test/png_rgb8_unfilter_tb.sv
